// ===== sv/gfb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gfb_pkg
// shared types and constants of the packed 4-bit gray frame buffer
// ----------------------------------------------------------------------------
package gfb_pkg;

   localparam int DISPLAY_WIDTH_DEF  = 128;
   localparam int DISPLAY_HEIGHT_DEF = 64;

   localparam logic [7:0] CMD_SET_COL = 8'h15;
   localparam logic [7:0] CMD_SET_ROW = 8'h75;
   localparam logic [7:0] NIBBLE_LO   = 8'h0F;
   localparam logic [7:0] NIBBLE_HI   = 8'hF0;

   localparam logic [2:0] CMD_COUNT_LAST = 3'd5;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_OPEN  = 2'd1,
      OP_FETCH = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_STATUS = 2'd0,
      KIND_CMD    = 2'd1,
      KIND_DATA   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_RANGE  = 2'd1,
      STATUS_NO_WIN = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      EMIT_NONE   = 2'd0,
      EMIT_STATUS = 2'd1,
      EMIT_CMD    = 2'd2,
      EMIT_DATA   = 2'd3
   } emit_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DISPATCH,
      ST_ADDR,
      ST_READ,
      ST_MERGE,
      ST_DATA,
      ST_CMD,
      ST_RANGE,
      ST_NO_WIN,
      ST_CLEAR,
      ST_CLEAR_DONE
   } state_type;

   typedef struct packed {
      logic       load;
      logic       addr_en;
      logic       rd_en;
      logic       merge_wr;
      logic       sweep_en;
      emit_type   emit;
      status_type code;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   out_free;
      logic   pix_ok;
      logic   win_ok;
      logic   win_active;
      logic   cmd_last;
      logic   sweep_last;
   } stat_type;

endpackage
`default_nettype wire

// ===== sv/gfb_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gfb_ctrl
// sequencer for pixel write, window open, byte fetch and store clear
// ----------------------------------------------------------------------------
module gfb_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire gfb_pkg::stat_type stat,
   output gfb_pkg::cmd_type      cmd
);

   gfb_pkg::state_type state_ff;
   gfb_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gfb_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gfb_pkg::ST_INIT: begin
            if (stat.sweep_last) state_in = gfb_pkg::ST_IDLE;
         end
         gfb_pkg::ST_IDLE: begin
            if (req_valid) state_in = gfb_pkg::ST_DISPATCH;
         end
         gfb_pkg::ST_DISPATCH: begin
            unique case (stat.op)
               gfb_pkg::OP_WRITE:
                  state_in = stat.pix_ok ? gfb_pkg::ST_ADDR : gfb_pkg::ST_RANGE;
               gfb_pkg::OP_OPEN:
                  state_in = stat.win_ok ? gfb_pkg::ST_CMD : gfb_pkg::ST_RANGE;
               gfb_pkg::OP_FETCH:
                  state_in = stat.win_active ? gfb_pkg::ST_ADDR : gfb_pkg::ST_NO_WIN;
               gfb_pkg::OP_CLEAR:
                  state_in = gfb_pkg::ST_CLEAR;
               default:
                  state_in = gfb_pkg::ST_IDLE;
            endcase
         end
         gfb_pkg::ST_ADDR: state_in = gfb_pkg::ST_READ;
         gfb_pkg::ST_READ: begin
            state_in = (stat.op == gfb_pkg::OP_WRITE) ? gfb_pkg::ST_MERGE
                                                      : gfb_pkg::ST_DATA;
         end
         gfb_pkg::ST_MERGE, gfb_pkg::ST_DATA, gfb_pkg::ST_RANGE,
         gfb_pkg::ST_NO_WIN, gfb_pkg::ST_CLEAR_DONE: begin
            if (stat.out_free) state_in = gfb_pkg::ST_IDLE;
         end
         gfb_pkg::ST_CMD: begin
            if (stat.out_free && stat.cmd_last) state_in = gfb_pkg::ST_IDLE;
         end
         gfb_pkg::ST_CLEAR: begin
            if (stat.sweep_last) state_in = gfb_pkg::ST_CLEAR_DONE;
         end
         default: state_in = gfb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.load     = 1'b0;
      cmd.addr_en  = 1'b0;
      cmd.rd_en    = 1'b0;
      cmd.merge_wr = 1'b0;
      cmd.sweep_en = 1'b0;
      cmd.emit     = gfb_pkg::EMIT_NONE;
      cmd.code     = gfb_pkg::STATUS_OK;
      unique case (state_ff)
         gfb_pkg::ST_INIT, gfb_pkg::ST_CLEAR: begin
            cmd.sweep_en = 1'b1;
         end
         gfb_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         gfb_pkg::ST_ADDR: cmd.addr_en = 1'b1;
         gfb_pkg::ST_READ: cmd.rd_en   = 1'b1;
         gfb_pkg::ST_MERGE: begin
            if (stat.out_free) begin
               cmd.merge_wr = 1'b1;
               cmd.emit     = gfb_pkg::EMIT_STATUS;
            end
         end
         gfb_pkg::ST_DATA: begin
            if (stat.out_free) cmd.emit = gfb_pkg::EMIT_DATA;
         end
         gfb_pkg::ST_CMD: begin
            if (stat.out_free) cmd.emit = gfb_pkg::EMIT_CMD;
         end
         gfb_pkg::ST_RANGE: begin
            if (stat.out_free) cmd.emit = gfb_pkg::EMIT_STATUS;
            cmd.code = gfb_pkg::STATUS_RANGE;
         end
         gfb_pkg::ST_NO_WIN: begin
            if (stat.out_free) cmd.emit = gfb_pkg::EMIT_STATUS;
            cmd.code = gfb_pkg::STATUS_NO_WIN;
         end
         gfb_pkg::ST_CLEAR_DONE: begin
            if (stat.out_free) cmd.emit = gfb_pkg::EMIT_STATUS;
         end
         default: ;
      endcase
   end

endmodule
`default_nettype wire

// ===== sv/gfb_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gfb_datapath
// packed frame store, window cursors, address unit and result register
// ----------------------------------------------------------------------------
module gfb_datapath #(
   parameter int DISPLAY_WIDTH  = gfb_pkg::DISPLAY_WIDTH_DEF,
   parameter int DISPLAY_HEIGHT = gfb_pkg::DISPLAY_HEIGHT_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [1:0]       req_op,
   input  wire logic [7:0]       req_x,
   input  wire logic [7:0]       req_y,
   input  wire logic [3:0]       req_color,
   input  wire logic [7:0]       req_x_stop,
   input  wire logic [7:0]       req_y_stop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [1:0]            rsp_kind,
   output logic [7:0]            rsp_out_byte,
   output logic [1:0]            rsp_status,
   output logic                  rsp_last,
   input  wire gfb_pkg::cmd_type cmd,
   output gfb_pkg::stat_type     stat
);

   localparam int STRIDE      = DISPLAY_WIDTH / 2;
   localparam int STORE_BYTES = ((DISPLAY_WIDTH + 1) / 2) * DISPLAY_HEIGHT;
   localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam logic [15:0] STRIDE_W = 16'(STRIDE);
   localparam logic [8:0]  WIDTH_W  = 9'(DISPLAY_WIDTH);
   localparam logic [8:0]  HEIGHT_W = 9'(DISPLAY_HEIGHT);
   localparam logic [AW-1:0] SWEEP_LAST = AW'(STORE_BYTES - 1);

   gfb_pkg::op_type op_ff;
   logic [7:0] x_ff, y_ff, xs_ff, ys_ff;
   logic [3:0] color_ff;

   logic [7:0]    store_ff [STORE_BYTES];
   logic [7:0]    rd_data_ff;
   logic [AW-1:0] addr_ff;
   logic [AW-1:0] sweep_ff;
   logic [2:0]    cnt_ff;

   logic [6:0] col_ff, col_start_ff, col_end_ff;
   logic [7:0] row_ff, row_end_ff;
   logic       active_ff;

   logic       rsp_valid_ff;
   logic [1:0] kind_ff, status_ff;
   logic [7:0] byte_ff;
   logic       last_ff;

   logic [1:0] kind_in, status_in;
   logic [7:0] byte_in;
   logic       last_in;

   logic          out_free;
   logic          pix_ok, win_ok, fetch_last;
   logic [6:0]    addr_col;
   logic [7:0]    addr_row;
   logic [15:0]   addr_sum;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic [7:0]    merged;

   assign out_free = !rsp_valid_ff || rsp_ready;

   assign pix_ok = ({1'b0, x_ff} < WIDTH_W) && ({1'b0, y_ff} < HEIGHT_W);
   assign win_ok = pix_ok && ({1'b0, xs_ff} < WIDTH_W) && ({1'b0, ys_ff} < HEIGHT_W);
   assign fetch_last = (col_ff == col_end_ff) && (row_ff == row_end_ff);

   always_comb begin
      stat.op         = op_ff;
      stat.out_free   = out_free;
      stat.pix_ok     = pix_ok;
      stat.win_ok     = win_ok;
      stat.win_active = active_ff;
      stat.cmd_last   = (cnt_ff == gfb_pkg::CMD_COUNT_LAST);
      stat.sweep_last = (sweep_ff == SWEEP_LAST);
   end

   // input capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= gfb_pkg::op_type'(req_op);
         x_ff     <= req_x;
         y_ff     <= req_y;
         color_ff <= req_color;
         xs_ff    <= req_x_stop;
         ys_ff    <= req_y_stop;
      end
   end

   // byte address
   assign addr_col = (op_ff == gfb_pkg::OP_WRITE) ? x_ff[7:1] : col_ff;
   assign addr_row = (op_ff == gfb_pkg::OP_WRITE) ? y_ff : row_ff;
   assign addr_sum = 16'(addr_col) + 16'(addr_row) * STRIDE_W;

   always_ff @(posedge clock) begin
      if (cmd.addr_en) addr_ff <= addr_sum[AW-1:0];
   end

   // frame store
   assign merged = x_ff[0] ? ((rd_data_ff & gfb_pkg::NIBBLE_HI) | {4'b0, color_ff})
                           : ((rd_data_ff & gfb_pkg::NIBBLE_LO) | {color_ff, 4'b0});
   assign wr_en   = cmd.sweep_en || cmd.merge_wr;
   assign wr_addr = cmd.sweep_en ? sweep_ff : addr_ff;
   assign wr_data = cmd.sweep_en ? 8'h00 : merged;

   always_ff @(posedge clock) begin
      if (wr_en) store_ff[wr_addr] <= wr_data;
      if (cmd.rd_en) rd_data_ff <= store_ff[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (cmd.sweep_en) begin
         sweep_ff <= (sweep_ff == SWEEP_LAST) ? '0 : sweep_ff + AW'(1);
      end
   end

   // command byte counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.load) begin
         cnt_ff <= '0;
      end else if (cmd.emit == gfb_pkg::EMIT_CMD) begin
         cnt_ff <= cnt_ff + 3'd1;
      end
   end

   // window cursors
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         col_start_ff <= '0;
         col_end_ff   <= '0;
         row_ff       <= '0;
         row_end_ff   <= '0;
         active_ff    <= 1'b0;
      end else begin
         case (cmd.emit)
            gfb_pkg::EMIT_CMD: begin
               if (cnt_ff == gfb_pkg::CMD_COUNT_LAST) begin
                  col_start_ff <= x_ff[7:1];
                  col_end_ff   <= xs_ff[7:1];
                  row_end_ff   <= ys_ff;
                  col_ff       <= x_ff[7:1];
                  row_ff       <= y_ff;
                  active_ff    <= (x_ff[7:1] <= xs_ff[7:1]) && (y_ff <= ys_ff);
               end
            end
            gfb_pkg::EMIT_DATA: begin
               if (col_ff == col_end_ff) begin
                  col_ff <= col_start_ff;
                  if (row_ff == row_end_ff) begin
                     active_ff <= 1'b0;
                  end else begin
                     row_ff <= row_ff + 8'd1;
                  end
               end else begin
                  col_ff <= col_ff + 7'd1;
               end
            end
            gfb_pkg::EMIT_STATUS: begin
               if (op_ff == gfb_pkg::OP_OPEN && cmd.code == gfb_pkg::STATUS_RANGE) begin
                  active_ff <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   // result payload
   always_comb begin
      kind_in   = gfb_pkg::KIND_STATUS;
      byte_in   = 8'h00;
      status_in = cmd.code;
      last_in   = 1'b1;
      case (cmd.emit)
         gfb_pkg::EMIT_CMD: begin
            kind_in   = gfb_pkg::KIND_CMD;
            status_in = gfb_pkg::STATUS_OK;
            last_in   = (cnt_ff == gfb_pkg::CMD_COUNT_LAST);
            case (cnt_ff)
               3'd0:    byte_in = gfb_pkg::CMD_SET_COL;
               3'd1:    byte_in = {1'b0, x_ff[7:1]};
               3'd2:    byte_in = {1'b0, xs_ff[7:1]};
               3'd3:    byte_in = gfb_pkg::CMD_SET_ROW;
               3'd4:    byte_in = y_ff;
               default: byte_in = ys_ff;
            endcase
         end
         gfb_pkg::EMIT_DATA: begin
            kind_in   = gfb_pkg::KIND_DATA;
            byte_in   = rd_data_ff;
            status_in = gfb_pkg::STATUS_OK;
            last_in   = fetch_last;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit != gfb_pkg::EMIT_NONE) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit != gfb_pkg::EMIT_NONE) begin
         kind_ff   <= kind_in;
         byte_ff   <= byte_in;
         status_ff <= status_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_status   = status_ff;
   assign rsp_last     = last_ff;

endmodule
`default_nettype wire

// ===== sv/gray4_frame_buffer_window_readout.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gray4_frame_buffer_window_readout
// 4-bit gray frame store, two pixels per byte, with window readout
// ----------------------------------------------------------------------------
// pixel write: dispatch, address, read, merge (read-modify-write of the packed byte);
//   byte fetch: dispatch, address, read, data; open window: dispatch, then one command
//   a cycle while output is free; error status from dispatch; clear sweeps the store
// one item at a time; the next transfer is taken while the last result waits
// reset: sweeps the whole store to zero, req_ready low
// ----------------------------------------------------------------------------
module gray4_frame_buffer_window_readout #(
   parameter int DISPLAY_WIDTH  = gfb_pkg::DISPLAY_WIDTH_DEF,
   parameter int DISPLAY_HEIGHT = gfb_pkg::DISPLAY_HEIGHT_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_op,
   input  wire logic [7:0] req_x,
   input  wire logic [7:0] req_y,
   input  wire logic [3:0] req_color,
   input  wire logic [7:0] req_x_stop,
   input  wire logic [7:0] req_y_stop,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [1:0]      rsp_kind,
   output logic [7:0]      rsp_out_byte,
   output logic [1:0]      rsp_status,
   output logic            rsp_last
);

   gfb_pkg::cmd_type  cmd;
   gfb_pkg::stat_type stat;

   gfb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   gfb_datapath #(
      .DISPLAY_WIDTH  (DISPLAY_WIDTH),
      .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_op       (req_op),
      .req_x        (req_x),
      .req_y        (req_y),
      .req_color    (req_color),
      .req_x_stop   (req_x_stop),
      .req_y_stop   (req_y_stop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_kind     (rsp_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last),
      .cmd          (cmd),
      .stat         (stat)
   );

endmodule
`default_nettype wire

// ===== verif/gray4_frame_buffer_window_readout_tb.sv =====
// ----------------------------------------------------------------------------
// gray4_frame_buffer_window_readout_tb
// self-checking bench: directed table, then random scenes of pixel writes,
// window readouts, clears and noise, checked against a shadow of the store
// ----------------------------------------------------------------------------
module gray4_frame_buffer_window_readout_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD  = 5;
   localparam int WIDTH        = gfb_pkg::DISPLAY_WIDTH_DEF;
   localparam int HEIGHT       = gfb_pkg::DISPLAY_HEIGHT_DEF;
   localparam int STRIDE       = WIDTH / 2;
   localparam int STORE_BYTES  = ((WIDTH + 1) / 2) * HEIGHT;
   localparam int TARGET_ITEMS = 470;
   localparam int MAX_CLEARS   = 6;
   localparam int HOLD_CYCLES  = 400;
   localparam int TAIL_CYCLES  = 50;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int NUM_DIRECTED = 26;

   typedef struct packed {
      gfb_pkg::op_type op;
      logic [7:0]      x;
      logic [7:0]      y;
      logic [3:0]      color;
      logic [7:0]      x_stop;
      logic [7:0]      y_stop;
   } pix_req_type;

   typedef struct packed {
      gfb_pkg::kind_type   kind;
      logic [7:0]          data;
      gfb_pkg::status_type status;
      logic                last;
   } panel_rsp_type;

   typedef struct packed {
      pix_req_type         req;
      logic                fixed;
      gfb_pkg::status_type fixed_status;
   } stim_row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_op;
   logic [7:0] req_x;
   logic [7:0] req_y;
   logic [3:0] req_color;
   logic [7:0] req_x_stop;
   logic [7:0] req_y_stop;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_status;
   logic       rsp_last;

   // shadow of the block
   logic [7:0] shadow_store [STORE_BYTES];
   logic [6:0] cur_col;
   logic [7:0] cur_row;
   logic [6:0] win_col_start;
   logic [6:0] win_col_end;
   logic [7:0] win_row_end;
   logic       win_open;

   panel_rsp_type step_rsp [$];
   panel_rsp_type expected_q [$];

   int errors        = 0;
   int n_items       = 0;
   int n_checked     = 0;
   int n_clears      = 0;
   int windows_done  = 0;
   int burst_left    = 0;
   int cycle_count   = 0;
   int op_count [4]  = '{0, 0, 0, 0};
   bit hold_req      = 1'b0;

   stim_row_type directed_rows [NUM_DIRECTED] = '{
      '{'{gfb_pkg::OP_FETCH, 8'd0, 8'd0, 4'h0, 8'd0, 8'd0}, 1'b1, gfb_pkg::STATUS_NO_WIN},
      '{'{gfb_pkg::OP_WRITE, 8'd0, 8'd0, 4'hF, 8'd0, 8'd0}, 1'b1, gfb_pkg::STATUS_OK},
      '{'{gfb_pkg::OP_WRITE, 8'd127, 8'd63, 4'hA, 8'd0, 8'd0}, 1'b1, gfb_pkg::STATUS_OK},
      '{'{gfb_pkg::OP_WRITE, 8'd128, 8'd0, 4'hF, 8'd0, 8'd0}, 1'b1, gfb_pkg::STATUS_RANGE},
      '{'{gfb_pkg::OP_WRITE, 8'd0, 8'd64, 4'hF, 8'd0, 8'd0}, 1'b1, gfb_pkg::STATUS_RANGE},
      '{'{gfb_pkg::OP_WRITE, 8'd255, 8'd255, 4'hF, 8'd255, 8'd255}, 1'b1,
        gfb_pkg::STATUS_RANGE},
      '{'{gfb_pkg::OP_WRITE, 8'd1, 8'd0, 4'h5, 8'd0, 8'd0}, 1'b1, gfb_pkg::STATUS_OK},
      '{'{gfb_pkg::OP_OPEN, 8'd0, 8'd0, 4'h0, 8'd3, 8'd1}, 1'b0, gfb_pkg::STATUS_OK},
      '{'{gfb_pkg::OP_FETCH, 8'd0, 8'd0, 4'h0, 8'd0, 8'd0}, 1'b0, gfb_pkg::STATUS_OK},
      '{'{gfb_pkg::OP_FETCH, 8'd0, 8'd0, 4'h0, 8'd0, 8'd0}, 1'b0, gfb_pkg::STATUS_OK},
      '{'{gfb_pkg::OP_FETCH, 8'd0, 8'd0, 4'h0, 8'd0, 8'd0}, 1'b0, gfb_pkg::STATUS_OK},
      '{'{gfb_pkg::OP_FETCH, 8'd0, 8'd0, 4'h0, 8'd0, 8'd0}, 1'b0, gfb_pkg::STATUS_OK},
      '{'{gfb_pkg::OP_FETCH, 8'd0, 8'd0, 4'h0, 8'd0, 8'd0}, 1'b1, gfb_pkg::STATUS_NO_WIN},
      '{'{gfb_pkg::OP_OPEN, 8'd4, 8'd0, 4'h0, 8'd2, 8'd0}, 1'b0, gfb_pkg::STATUS_OK},
      '{'{gfb_pkg::OP_FETCH, 8'd0, 8'd0, 4'h0, 8'd0, 8'd0}, 1'b1, gfb_pkg::STATUS_NO_WIN},
      '{'{gfb_pkg::OP_OPEN, 8'd0, 8'd5, 4'h0, 8'd1, 8'd3}, 1'b0, gfb_pkg::STATUS_OK},
      '{'{gfb_pkg::OP_FETCH, 8'd0, 8'd0, 4'h0, 8'd0, 8'd0}, 1'b1, gfb_pkg::STATUS_NO_WIN},
      '{'{gfb_pkg::OP_OPEN, 8'd0, 8'd0, 4'h0, 8'd127, 8'd63}, 1'b0, gfb_pkg::STATUS_OK},
      '{'{gfb_pkg::OP_FETCH, 8'd0, 8'd0, 4'h0, 8'd0, 8'd0}, 1'b0, gfb_pkg::STATUS_OK},
      '{'{gfb_pkg::OP_WRITE, 8'd2, 8'd0, 4'h7, 8'd0, 8'd0}, 1'b1, gfb_pkg::STATUS_OK},
      '{'{gfb_pkg::OP_FETCH, 8'd0, 8'd0, 4'h0, 8'd0, 8'd0}, 1'b0, gfb_pkg::STATUS_OK},
      '{'{gfb_pkg::OP_CLEAR, 8'd0, 8'd0, 4'h0, 8'd0, 8'd0}, 1'b1, gfb_pkg::STATUS_OK},
      '{'{gfb_pkg::OP_FETCH, 8'd0, 8'd0, 4'h0, 8'd0, 8'd0}, 1'b0, gfb_pkg::STATUS_OK},
      '{'{gfb_pkg::OP_OPEN, 8'd0, 8'd0, 4'h0, 8'd200, 8'd63}, 1'b1, gfb_pkg::STATUS_RANGE},
      '{'{gfb_pkg::OP_FETCH, 8'd0, 8'd0, 4'h0, 8'd0, 8'd0}, 1'b1, gfb_pkg::STATUS_NO_WIN},
      '{'{gfb_pkg::OP_OPEN, 8'd126, 8'd63, 4'h0, 8'd127, 8'd63}, 1'b0, gfb_pkg::STATUS_OK}
   };

   gray4_frame_buffer_window_readout dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_x        (req_x),
      .req_y        (req_y),
      .req_color    (req_color),
      .req_x_stop   (req_x_stop),
      .req_y_stop   (req_y_stop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_kind     (rsp_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   function automatic int unsigned store_index(input logic [6:0] col, input logic [7:0] row);
      int unsigned idx;
      idx = col + row * STRIDE;
      return (idx < STORE_BYTES) ? idx : 0;
   endfunction

   function automatic panel_rsp_type status_rsp(input gfb_pkg::status_type code);
      panel_rsp_type r;
      r.kind   = gfb_pkg::KIND_STATUS;
      r.data   = 8'h00;
      r.status = code;
      r.last   = 1'b1;
      return r;
   endfunction

   function automatic panel_rsp_type cmd_rsp(input logic [7:0] data, input logic last);
      panel_rsp_type r;
      r.kind   = gfb_pkg::KIND_CMD;
      r.data   = data;
      r.status = gfb_pkg::STATUS_OK;
      r.last   = last;
      return r;
   endfunction

   // shadow frame store and window cursor, advanced once per accepted transfer
   function automatic void predict_panel(input pix_req_type r);
      int unsigned   idx;
      panel_rsp_type d;
      step_rsp.delete();
      case (r.op)
         gfb_pkg::OP_WRITE: begin
            if (r.x >= WIDTH || r.y >= HEIGHT) begin
               step_rsp.push_back(status_rsp(gfb_pkg::STATUS_RANGE));
            end else begin
               idx = store_index(r.x[7:1], r.y);
               if (r.x[0]) begin
                  shadow_store[idx] = (shadow_store[idx] & gfb_pkg::NIBBLE_HI)
                                    | {4'h0, r.color};
               end else begin
                  shadow_store[idx] = (shadow_store[idx] & gfb_pkg::NIBBLE_LO)
                                    | {r.color, 4'h0};
               end
               step_rsp.push_back(status_rsp(gfb_pkg::STATUS_OK));
            end
         end
         gfb_pkg::OP_OPEN: begin
            if (r.x >= WIDTH || r.y >= HEIGHT || r.x_stop >= WIDTH || r.y_stop >= HEIGHT) begin
               win_open = 1'b0;
               step_rsp.push_back(status_rsp(gfb_pkg::STATUS_RANGE));
            end else begin
               step_rsp.push_back(cmd_rsp(gfb_pkg::CMD_SET_COL, 1'b0));
               step_rsp.push_back(cmd_rsp({1'b0, r.x[7:1]}, 1'b0));
               step_rsp.push_back(cmd_rsp({1'b0, r.x_stop[7:1]}, 1'b0));
               step_rsp.push_back(cmd_rsp(gfb_pkg::CMD_SET_ROW, 1'b0));
               step_rsp.push_back(cmd_rsp(r.y, 1'b0));
               step_rsp.push_back(cmd_rsp(r.y_stop, 1'b1));
               win_col_start = r.x[7:1];
               win_col_end   = r.x_stop[7:1];
               win_row_end   = r.y_stop;
               cur_col       = win_col_start;
               cur_row       = r.y;
               win_open      = (win_col_start <= win_col_end) && (r.y <= r.y_stop);
            end
         end
         gfb_pkg::OP_FETCH: begin
            if (!win_open) begin
               step_rsp.push_back(status_rsp(gfb_pkg::STATUS_NO_WIN));
            end else begin
               d.kind   = gfb_pkg::KIND_DATA;
               d.data   = shadow_store[store_index(cur_col, cur_row)];
               d.status = gfb_pkg::STATUS_OK;
               d.last   = 1'b0;
               if (cur_col == win_col_end) begin
                  cur_col = win_col_start;
                  if (cur_row == win_row_end) begin
                     d.last   = 1'b1;
                     win_open = 1'b0;
                     windows_done++;
                  end else begin
                     cur_row = cur_row + 8'd1;
                  end
               end else begin
                  cur_col = cur_col + 7'd1;
               end
               step_rsp.push_back(d);
            end
         end
         default: begin
            foreach (shadow_store[i]) shadow_store[i] = 8'h00;
            n_clears++;
            step_rsp.push_back(status_rsp(gfb_pkg::STATUS_OK));
         end
      endcase
   endfunction

   function automatic pix_req_type any_req(input gfb_pkg::op_type op);
      pix_req_type r;
      r.op     = op;
      r.x      = 8'($urandom);
      r.y      = 8'($urandom);
      r.color  = 4'($urandom);
      r.x_stop = 8'($urandom);
      r.y_stop = 8'($urandom);
      return r;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: mismatch on %s: expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   // one transfer on the request side, with burst and gap idling
   task automatic send_item(input pix_req_type r, input logic fixed,
                            input gfb_pkg::status_type fixed_status);
      int gap;
      @(negedge clock);
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
      end
      burst_left--;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_op     <= r.op;
      req_x      <= r.x;
      req_y      <= r.y;
      req_color  <= r.color;
      req_x_stop <= r.x_stop;
      req_y_stop <= r.y_stop;
      req_valid  <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_panel(r);
      if (fixed) begin
         expected_q.push_back(status_rsp(fixed_status));
      end else begin
         foreach (step_rsp[i]) expected_q.push_back(step_rsp[i]);
      end
      n_items++;
      op_count[r.op]++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      panel_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result: expected none, got kind=%0d byte=%02h",
                     $time, rsp_kind, rsp_out_byte);
            $display("   status=%0d last=%0b", rsp_status, rsp_last);
            errors++;
         end else begin
            want = expected_q.pop_front();
            n_checked++;
            check_field("kind", want.kind, rsp_kind);
            check_field("out_byte", want.data, rsp_out_byte);
            check_field("status", want.status, rsp_status);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_q.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver: changing stall patterns, plus a long hold-off on request
   initial begin
      int stall_mode;
      int stall_phase;
      int hold_left;
      stall_mode  = 0;
      stall_phase = 0;
      hold_left   = 0;
      rsp_ready   = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
         end
         if (stall_phase == 0) begin
            stall_mode  = $urandom_range(0, 3);
            stall_phase = $urandom_range(20, 120);
         end
         stall_phase--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (stall_mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               2:       rsp_ready <= (stall_phase % 4 != 0);
               default: rsp_ready <= (stall_phase % 3 == 0);
            endcase
         end
      end
   end

   initial begin
      pix_req_type r;
      int scene;
      int shape;
      int nbytes;
      int c0, c1, y0, y1;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_op     = gfb_pkg::OP_WRITE;
      req_x      = 8'd0;
      req_y      = 8'd0;
      req_color  = 4'd0;
      req_x_stop = 8'd0;
      req_y_stop = 8'd0;
      foreach (shadow_store[i]) shadow_store[i] = 8'h00;
      cur_col       = 7'd0;
      cur_row       = 8'd0;
      win_col_start = 7'd0;
      win_col_end   = 7'd0;
      win_row_end   = 8'd0;
      win_open      = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].fixed_status);
      end

      // receiver holds off while writes keep coming, then drain completely
      wait_drained();
      hold_req = 1'b1;
      repeat (12) begin
         r   = any_req(gfb_pkg::OP_WRITE);
         r.x = 8'($urandom_range(0, WIDTH - 1));
         r.y = 8'($urandom_range(0, HEIGHT - 1));
         send_item(r, 1'b0, gfb_pkg::STATUS_OK);
      end
      wait_drained();

      while (n_items < TARGET_ITEMS) begin
         scene = $urandom_range(0, 9);
         if (scene <= 5) begin
            // window scene: seed pixels, open, read out with writes mixed in
            c0 = $urandom_range(0, STRIDE - 1);
            y0 = $urandom_range(0, HEIGHT - 1);
            c1 = c0 + $urandom_range(0, 3);
            y1 = y0 + $urandom_range(0, 3);
            shape = $urandom_range(0, 9);
            if (shape == 3) begin
               c1 = c0;
               y1 = y0 + 12;
            end
            if (c1 > STRIDE - 1) c1 = STRIDE - 1;
            if (y1 > HEIGHT - 1) y1 = HEIGHT - 1;
            repeat ($urandom_range(1, 4)) begin
               r   = any_req(gfb_pkg::OP_WRITE);
               r.x = 8'($urandom_range(2 * c0, 2 * c1 + 1));
               r.y = 8'($urandom_range(y0, y1));
               send_item(r, 1'b0, gfb_pkg::STATUS_OK);
            end
            r        = any_req(gfb_pkg::OP_OPEN);
            r.x      = 8'(2 * c0 + $urandom_range(0, 1));
            r.x_stop = 8'(2 * c1 + $urandom_range(0, 1));
            r.y      = 8'(y0);
            r.y_stop = 8'(y1);
            nbytes   = (c1 - c0 + 1) * (y1 - y0 + 1) + $urandom_range(0, 1);
            if (shape == 0 && y0 > 0) begin
               r.y_stop = 8'($urandom_range(0, y0 - 1));
               nbytes   = 1;
            end else if (shape == 1 && c0 > 0) begin
               r.x_stop = 8'($urandom_range(0, 2 * c0 - 1));
               nbytes   = 1;
            end else if (shape == 2) begin
               case ($urandom_range(0, 3))
                  0:       r.x      = 8'($urandom_range(WIDTH, 255));
                  1:       r.y      = 8'($urandom_range(HEIGHT, 255));
                  2:       r.x_stop = 8'($urandom_range(WIDTH, 255));
                  default: r.y_stop = 8'($urandom_range(HEIGHT, 255));
               endcase
               nbytes = 1;
            end
            send_item(r, 1'b0, gfb_pkg::STATUS_OK);
            repeat (nbytes) begin
               if ($urandom_range(0, 4) == 0) begin
                  r   = any_req(gfb_pkg::OP_WRITE);
                  r.x = 8'($urandom_range(2 * c0, 2 * c1 + 1));
                  r.y = 8'($urandom_range(y0, y1));
                  send_item(r, 1'b0, gfb_pkg::STATUS_OK);
               end
               send_item(any_req(gfb_pkg::OP_FETCH), 1'b0, gfb_pkg::STATUS_OK);
            end
         end else if (scene <= 7) begin
            repeat ($urandom_range(1, 5)) begin
               r = any_req(gfb_pkg::op_type'($urandom_range(0, 2)));
               send_item(r, 1'b0, gfb_pkg::STATUS_OK);
            end
         end else if (scene == 8) begin
            repeat ($urandom_range(2, 8)) begin
               r = any_req(gfb_pkg::OP_WRITE);
               if ($urandom_range(0, 7) != 0) begin
                  r.x = 8'($urandom_range(0, WIDTH - 1));
                  r.y = 8'($urandom_range(0, HEIGHT - 1));
               end
               send_item(r, 1'b0, gfb_pkg::STATUS_OK);
            end
         end else begin
            r = any_req((n_clears < MAX_CLEARS) ? gfb_pkg::OP_CLEAR : gfb_pkg::OP_FETCH);
            send_item(r, 1'b0, gfb_pkg::STATUS_OK);
         end
         if ($urandom_range(0, 15) == 0) wait_drained();
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("sent %0d transfers: %0d writes, %0d opens, %0d fetches, %0d clears",
               n_items, op_count[gfb_pkg::OP_WRITE], op_count[gfb_pkg::OP_OPEN],
               op_count[gfb_pkg::OP_FETCH], op_count[gfb_pkg::OP_CLEAR]);
      $display("checked %0d results, %0d windows read to the last byte, %0d mismatches",
               n_checked, windows_done, errors);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
